// ----- design/itrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// itrgb_pkg
// Shared widths, colour knots and special colours of the intensity colormap.
// ----------------------------------------------------------------------------
`default_nettype none

package itrgb_pkg;

	localparam int IN_W          = 16;
	localparam int CH_W          = 8;
	localparam int NUM_CH        = 3;
	localparam int NUM_KNOT      = 7;
	localparam int FRAC_BITS_DEF = 14;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef logic [CH_W-1:0] chan_t;

	// colour at each breakpoint, per channel
	localparam chan_t KNOT [NUM_CH][NUM_KNOT] = '{
		'{8'd64,  8'd0,   8'd0,   8'd32,  8'd233, 8'd255, 8'd191},
		'{8'd0,   8'd32,  8'd233, 8'd255, 8'd233, 8'd32,  8'd0},
		'{8'd191, 8'd255, 8'd233, 8'd32,  8'd0,   8'd0,   8'd0}
	};

	// below zero
	localparam chan_t UNDER_COLOR [NUM_CH] = '{8'd72, 8'd0, 8'd72};
	// above one
	localparam chan_t OVER_COLOR [NUM_CH] = '{8'd255, 8'd248, 8'd220};

endpackage

`default_nettype wire

// ----- design/intensity_to_rgb_colormap_unit.sv -----
// ----------------------------------------------------------------------------
// intensity_to_rgb_colormap_unit
// Piecewise-linear colormap from a signed fixed-point intensity to 8-bit RGB.
//
// Input channel: intensity with intensity_valid / intensity_stall. A transfer
// takes place at a rising edge with valid high and stall low. The sample has
// FRAC_BITS fractional bits, so 2^FRAC_BITS stands for 1.0.
// Output channel: red, green, blue with rgb_valid / rgb_stall, same rule.
// Every input transfer gives exactly one output transfer, in order.
// One sample enters per cycle while intensity_stall is low. The five stages
// are segment search, table lookup and offset multiply, reciprocal multiply,
// remainder, and correction with the output register.
// Reset clears all stage valid bits; the pipe is empty afterwards.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling bubbles; intensity_stall rises only when all
// five stages hold a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module intensity_to_rgb_colormap_unit #(
	parameter int FRAC_BITS = itrgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [itrgb_pkg::IN_W-1:0]   intensity,
	input  wire logic                                intensity_valid,
	output logic                                     intensity_stall,
	output logic             [itrgb_pkg::CH_W-1:0]   red,
	output logic             [itrgb_pkg::CH_W-1:0]   green,
	output logic             [itrgb_pkg::CH_W-1:0]   blue,
	output logic                                     rgb_valid,
	input  wire logic                                rgb_stall
);

	localparam int NC  = itrgb_pkg::NUM_CH;
	localparam int CW  = itrgb_pkg::CH_W;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int K   = FRAC_BITS + CW;
	localparam int RW  = CW + 4;
	localparam int HW  = FRAC_BITS + 1;

	localparam int P1 = ONE >> 3;
	localparam int P2 = (4 * ONE + 5) / 10;
	localparam int P3 = ONE >> 1;
	localparam int P4 = (6 * ONE + 5) / 10;
	localparam int P5 = (7 * ONE) >> 3;

	localparam logic [HW-1:0] B1 = HW'(P1);
	localparam logic [HW-1:0] B2 = HW'(P2);
	localparam logic [HW-1:0] B3 = HW'(P3);
	localparam logic [HW-1:0] B4 = HW'(P4);
	localparam logic [HW-1:0] B5 = HW'(P5);

	localparam int W0 = P1;
	localparam int W1 = P2 - P1;
	localparam int W2 = P3 - P2;
	localparam int W3 = P4 - P3;
	localparam int W4 = P5 - P4;
	localparam int W5 = ONE - P5;

	localparam int R0 = (1 << K) / W0;
	localparam int R1 = (1 << K) / W1;
	localparam int R2 = (1 << K) / W2;
	localparam int R3 = (1 << K) / W3;
	localparam int R4 = (1 << K) / W4;
	localparam int R5 = (1 << K) / W5;

	typedef logic [CW-1:0] ch_t;

	// stage valid bits and advance chain
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !valid_s5 || !rgb_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign intensity_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= intensity_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: special ranges, segment search, offset into segment
	logic                 under_n, over_n;
	logic [HW-1:0]        hu;
	logic [2:0]           seg_n;
	logic [HW-1:0]        start_n;
	logic [HW-1:0]        off_full;
	logic                 under_s1, over_s1;
	logic [2:0]           seg_s1;
	logic [FRAC_BITS-1:0] off_s1;

	always_comb begin
		under_n = intensity[itrgb_pkg::IN_W-1];
		over_n  = intensity > $signed(itrgb_pkg::IN_W'(ONE));
		hu      = intensity[HW-1:0];
		if (hu > B5)      seg_n = 3'd5;
		else if (hu > B4) seg_n = 3'd4;
		else if (hu > B3) seg_n = 3'd3;
		else if (hu > B2) seg_n = 3'd2;
		else if (hu > B1) seg_n = 3'd1;
		else              seg_n = 3'd0;
		case (seg_n)
			3'd1:    start_n = B1;
			3'd2:    start_n = B2;
			3'd3:    start_n = B3;
			3'd4:    start_n = B4;
			3'd5:    start_n = B5;
			default: start_n = '0;
		endcase
		off_full = hu - start_n;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			under_s1 <= under_n;
			over_s1  <= over_n;
			seg_s1   <= seg_n;
			off_s1   <= off_full[FRAC_BITS-1:0];
		end
	end

	// stage 2: knot lookup, step magnitude times offset, width and reciprocal
	logic [2:0]           seg_up;
	ch_t                  c0_n  [NC];
	ch_t                  c1_n  [NC];
	logic                 dn_n  [NC];
	ch_t                  mag_n [NC];
	logic [K-1:0]         x_n   [NC];
	logic [FRAC_BITS-1:0] w_n;
	logic [RW-1:0]        r_n;

	logic                 under_s2, over_s2;
	ch_t                  c0_s2 [NC];
	logic                 dn_s2 [NC];
	logic [K-1:0]         x_s2  [NC];
	logic [FRAC_BITS-1:0] w_s2;
	logic [RW-1:0]        r_s2;

	always_comb begin
		seg_up = seg_s1 + 3'd1;
		for (int c = 0; c < NC; c++) begin
			c0_n[c]  = itrgb_pkg::KNOT[c][seg_s1];
			c1_n[c]  = itrgb_pkg::KNOT[c][seg_up];
			dn_n[c]  = c1_n[c] < c0_n[c];
			mag_n[c] = dn_n[c] ? c0_n[c] - c1_n[c] : c1_n[c] - c0_n[c];
			x_n[c]   = K'(mag_n[c]) * K'(off_s1);
		end
		case (seg_s1)
			3'd0: begin w_n = FRAC_BITS'(W0); r_n = RW'(R0); end
			3'd1: begin w_n = FRAC_BITS'(W1); r_n = RW'(R1); end
			3'd2: begin w_n = FRAC_BITS'(W2); r_n = RW'(R2); end
			3'd3: begin w_n = FRAC_BITS'(W3); r_n = RW'(R3); end
			3'd4: begin w_n = FRAC_BITS'(W4); r_n = RW'(R4); end
			default: begin w_n = FRAC_BITS'(W5); r_n = RW'(R5); end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			under_s2 <= under_s1;
			over_s2  <= over_s1;
			w_s2     <= w_n;
			r_s2     <= r_n;
			for (int c = 0; c < NC; c++) begin
				c0_s2[c] <= c0_n[c];
				dn_s2[c] <= dn_n[c];
				x_s2[c]  <= x_n[c];
			end
		end
	end

	// stage 3: quotient estimate by reciprocal, at most one short
	logic [K+RW-1:0]      prod_n [NC];
	logic                 under_s3, over_s3;
	ch_t                  c0_s3 [NC];
	logic                 dn_s3 [NC];
	logic [K-1:0]         x_s3  [NC];
	ch_t                  qe_s3 [NC];
	logic [FRAC_BITS-1:0] w_s3;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			prod_n[c] = (K+RW)'(x_s2[c]) * (K+RW)'(r_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			under_s3 <= under_s2;
			over_s3  <= over_s2;
			w_s3     <= w_s2;
			for (int c = 0; c < NC; c++) begin
				c0_s3[c] <= c0_s2[c];
				dn_s3[c] <= dn_s2[c];
				x_s3[c]  <= x_s2[c];
				qe_s3[c] <= prod_n[c][K+CW-1:K];
			end
		end
	end

	// stage 4: remainder of the estimate
	logic [K-1:0]         qw_n [NC];
	logic                 under_s4, over_s4;
	ch_t                  c0_s4  [NC];
	logic                 dn_s4  [NC];
	ch_t                  qe_s4  [NC];
	logic [K-1:0]         rem_s4 [NC];
	logic [FRAC_BITS-1:0] w_s4;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			qw_n[c] = K'(qe_s3[c]) * K'(w_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			under_s4 <= under_s3;
			over_s4  <= over_s3;
			w_s4     <= w_s3;
			for (int c = 0; c < NC; c++) begin
				c0_s4[c]  <= c0_s3[c];
				dn_s4[c]  <= dn_s3[c];
				qe_s4[c]  <= qe_s3[c];
				rem_s4[c] <= x_s3[c] - qw_n[c];
			end
		end
	end

	// stage 5: correct quotient, floor toward the lower colour, special colours
	logic [K-1:0] wk;
	logic         ge_n   [NC];
	logic [K-1:0] rem2_n [NC];
	ch_t          q_n    [NC];
	ch_t          res_n  [NC];
	ch_t          chan_s5 [NC];

	always_comb begin
		wk = K'(w_s4);
		for (int c = 0; c < NC; c++) begin
			ge_n[c]   = rem_s4[c] >= wk;
			rem2_n[c] = ge_n[c] ? rem_s4[c] - wk : rem_s4[c];
			q_n[c]    = qe_s4[c] + CW'(ge_n[c]);
			if (under_s4)
				res_n[c] = itrgb_pkg::UNDER_COLOR[c];
			else if (over_s4)
				res_n[c] = itrgb_pkg::OVER_COLOR[c];
			else if (dn_s4[c])
				res_n[c] = c0_s4[c] - q_n[c] - CW'(rem2_n[c] != '0);
			else
				res_n[c] = c0_s4[c] + q_n[c];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			for (int c = 0; c < NC; c++) begin
				chan_s5[c] <= res_n[c];
			end
		end
	end

	assign rgb_valid = valid_s5;
	assign red       = chan_s5[itrgb_pkg::CH_RED];
	assign green     = chan_s5[itrgb_pkg::CH_GREEN];
	assign blue      = chan_s5[itrgb_pkg::CH_BLUE];

endmodule

`default_nettype wire

// ----- design/itrgb_checker.sv -----
// ----------------------------------------------------------------------------
// itrgb_checker
// Port-level checks of the intensity colormap, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itrgb_checker #(
	parameter int FRAC_BITS = itrgb_pkg::FRAC_BITS_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic signed [itrgb_pkg::IN_W-1:0] intensity,
	input wire logic                              intensity_valid,
	input wire logic                              intensity_stall,
	input wire logic        [itrgb_pkg::CH_W-1:0] red,
	input wire logic        [itrgb_pkg::CH_W-1:0] green,
	input wire logic        [itrgb_pkg::CH_W-1:0] blue,
	input wire logic                              rgb_valid,
	input wire logic                              rgb_stall
);

	localparam logic signed [itrgb_pkg::IN_W-1:0] ONE_V = itrgb_pkg::IN_W'(1 << FRAC_BITS);

	logic in_xfer;
	assign in_xfer = intensity_valid && !intensity_stall;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("result changed while stalled");

	// input backs up only when the output is full and stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		intensity_stall |-> rgb_valid && rgb_stall)
		else $error("input stalled with room in the pipe");

	// negative sample reaches the output as violet when the output does not stall
	a_under: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && intensity[itrgb_pkg::IN_W-1] ##1 !rgb_stall ##1 !rgb_stall
			##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid
			&& red == itrgb_pkg::UNDER_COLOR[itrgb_pkg::CH_RED]
			&& green == itrgb_pkg::UNDER_COLOR[itrgb_pkg::CH_GREEN]
			&& blue == itrgb_pkg::UNDER_COLOR[itrgb_pkg::CH_BLUE])
		else $error("negative sample not mapped to violet");

	// sample above one reaches the output as cream when the output does not stall
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && intensity > ONE_V ##1 !rgb_stall ##1 !rgb_stall
			##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid
			&& red == itrgb_pkg::OVER_COLOR[itrgb_pkg::CH_RED]
			&& green == itrgb_pkg::OVER_COLOR[itrgb_pkg::CH_GREEN]
			&& blue == itrgb_pkg::OVER_COLOR[itrgb_pkg::CH_BLUE])
		else $error("sample above one not mapped to cream");

endmodule

bind intensity_to_rgb_colormap_unit itrgb_checker #(.FRAC_BITS(FRAC_BITS)) u_itrgb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.intensity       (intensity),
	.intensity_valid (intensity_valid),
	.intensity_stall (intensity_stall),
	.red             (red),
	.green           (green),
	.blue            (blue),
	.rgb_valid       (rgb_valid),
	.rgb_stall       (rgb_stall)
);

`default_nettype wire
